// ----- design/sfq_pkg.sv -----
// Shared types and constants for the shortest-first sorted queue.
package sfq_pkg;

   localparam int KEY_W         = 16;
   localparam int TAG_W         = 16;
   localparam int OCC_W         = 8;
   localparam int STATUS_W      = 2;
   localparam int DEFAULT_DEPTH = 128;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY_ERR  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL_ERR   = 2'd2;

   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } entry_type;

   typedef struct packed {
      logic             insert;
      logic             remove;
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } cmd_type;

endpackage

// ----- design/sfq_cell.sv -----
// One storage cell of the sorted chain, holding a single key and tag.
module sfq_cell
   import sfq_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cmd_type   cmd,
   input  entry_type left_entry,
   input  logic      left_place,
   input  entry_type right_entry,
   output entry_type entry,
   output logic      place
);

   entry_type entry_ff;
   entry_type entry_in;

   // A cell is displaced by an insert when it is empty or holds a larger key.
   assign place = !entry_ff.valid || (entry_ff.key > cmd.key);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert && place) begin
         if (left_place) begin
            entry_in = left_entry;
         end else begin
            entry_in.valid = 1'b1;
            entry_in.key   = cmd.key;
            entry_in.tag   = cmd.tag;
         end
      end else if (cmd.remove) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff.key <= entry_in.key;
      entry_ff.tag <= entry_in.tag;
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
   end

   assign entry = entry_ff;

endmodule

// ----- design/shortest_first_sorted_queue_core.sv -----
// Top level of the shortest-first sorted queue built as a chain of cells.
// A result beat is registered and appears in the cycle after its request beat is accepted.
// Throughput: one request per cycle while each result beat is taken; every cell compares and shifts in that cycle.
// The output register holds a result while the next request is accepted.
// Reset clears the cell valid bits, the count and the output valid at once.
// There is no clearing pass; the queue accepts requests right after reset.
module shortest_first_sorted_queue_core
   import sfq_pkg::*;
#(
   parameter int DEPTH = DEFAULT_DEPTH
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // key_length[15:0], tag[31:16]
   input  logic [0:0]  req_tuser,  // operation[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // removed_key[15:0], removed_tag[31:16], occupancy[39:32]
   output logic [1:0]  rsp_tuser   // status[1:0]
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   logic [CNT_W-1:0]    count_ff, count_in;
   logic                out_valid_ff;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [KEY_W-1:0]    rkey_ff, rkey_in;
   logic [TAG_W-1:0]    rtag_ff, rtag_in;
   logic [OCC_W-1:0]    occ_ff;

   logic      accept, full, empty, op;
   cmd_type   cmd;
   entry_type chain_w [DEPTH+1];
   logic      place_w [DEPTH+1];
   entry_type empty_entry;

   assign req_tready = !out_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign op         = req_tuser[0];
   assign full       = (count_ff == DEPTH_CNT);
   assign empty      = (count_ff == '0);

   assign cmd.insert = accept && (op == OP_INSERT) && !full;
   assign cmd.remove = accept && (op == OP_REMOVE) && !empty;
   assign cmd.key    = req_tdata[15:0];
   assign cmd.tag    = req_tdata[31:16];

   assign empty_entry.valid = 1'b0;
   assign empty_entry.key   = '0;
   assign empty_entry.tag   = '0;

   // The virtual cell beyond the last one reads as empty, the one before the first never shifts.
   assign chain_w[DEPTH] = empty_entry;
   assign place_w[0]     = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_w;
      if (i == 0) begin : g_first
         assign left_w = empty_entry;
      end else begin : g_rest
         assign left_w = chain_w[i-1];
      end
      sfq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_entry  (left_w),
         .left_place  (place_w[i]),
         .right_entry (chain_w[i+1]),
         .entry       (chain_w[i]),
         .place       (place_w[i+1])
      );
   end

   always_comb begin
      count_in  = count_ff;
      status_in = STATUS_DONE;
      rkey_in   = '0;
      rtag_in   = '0;
      if (op == OP_INSERT) begin
         if (full) begin
            status_in = STATUS_FULL_ERR;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end else begin
         if (empty) begin
            status_in = STATUS_EMPTY_ERR;
         end else begin
            count_in = count_ff - 1'b1;
            rkey_in  = chain_w[0].key;
            rtag_in  = chain_w[0].tag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         status_ff <= status_in;
         rkey_ff   <= rkey_in;
         rtag_ff   <= rtag_in;
         occ_ff    <= OCC_W'(count_in);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {occ_ff, rtag_ff, rkey_ff};
   assign rsp_tuser  = status_ff;

endmodule

// ----- design/sfq_checker.sv -----
// Port-level checks for the shortest-first sorted queue, bound to the top level.
module sfq_checker
   import sfq_pkg::*;
#(
   parameter int DEPTH = DEFAULT_DEPTH
)
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic [0:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   localparam logic [OCC_W-1:0] DEPTH_OCC = OCC_W'(DEPTH);

   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == STATUS_EMPTY_ERR) |-> (rsp_tdata[39:32] == '0))
      else $error("Empty-queue error beat reports nonzero occupancy.");

   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == STATUS_FULL_ERR) |-> (rsp_tdata[39:32] == DEPTH_OCC))
      else $error("Full-queue error beat reports wrong occupancy.");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != STATUS_DONE) |-> (rsp_tdata[31:0] == '0))
      else $error("Error beat carries a nonzero removed entry.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("Stalled result beat changed.");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && !req_tready) |=> (req_tvalid && $stable(req_tdata) && $stable(req_tuser)))
      else $error("Waiting request beat changed.");

endmodule

bind shortest_first_sorted_queue_core sfq_checker #(.DEPTH(DEPTH)) u_sfq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
